// ===== design/i2cms_pkg.sv =====
`timescale 1ns / 1ps

package i2cms_pkg;

   // Command codes carried in the operation field
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   localparam int UNIT_W  = 10;
   localparam int BYTE_W  = 8;
   localparam int PHASE_W = 3;
   localparam int COUNT_W = 4;
   localparam int DELAY_W = 3;
   localparam int DATA_W  = 16;

   // Segment delays in units
   localparam logic [DELAY_W-1:0] UNITS_SETUP = 3'd3;
   localparam logic [DELAY_W-1:0] UNITS_HIGH  = 3'd5;
   localparam logic [DELAY_W-1:0] UNITS_HOLD  = 3'd2;

   localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [2:0]        operation;
      logic [BYTE_W-1:0] write_byte;
      logic              ack_to_send;
      logic              sda_in;
   } req_item_type;

   typedef struct packed {
      logic              scl_out;
      logic              sda_out;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_byte;
      logic              ack_received;
   } rsp_item_type;

endpackage

// ===== design/i2cms_seq.sv =====
`timescale 1ns / 1ps

module i2cms_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  i2cms_pkg::req_item_type     item,
   input  logic [i2cms_pkg::UNIT_W-1:0] unit_ticks,
   output i2cms_pkg::rsp_item_type     result
);
   import i2cms_pkg::*;

   // Start / stop last phases
   localparam logic [PHASE_W-1:0] START_LAST = 3'd3;
   localparam logic [PHASE_W-1:0] STOP_LAST  = 3'd2;
   // Write phases
   localparam logic [PHASE_W-1:0] WR_DATA    = 3'd0;
   localparam logic [PHASE_W-1:0] WR_SCL_HI  = 3'd1;
   localparam logic [PHASE_W-1:0] WR_SCL_LO  = 3'd2;
   localparam logic [PHASE_W-1:0] WR_REL     = 3'd3;
   localparam logic [PHASE_W-1:0] WR_ACK_HI  = 3'd4;
   localparam logic [PHASE_W-1:0] WR_ACK_SMP = 3'd5;
   localparam logic [PHASE_W-1:0] WR_LAST    = 3'd6;
   // Read phases
   localparam logic [PHASE_W-1:0] RD_REL     = 3'd0;
   localparam logic [PHASE_W-1:0] RD_SCL_HI  = 3'd1;
   localparam logic [PHASE_W-1:0] RD_SMP     = 3'd2;
   localparam logic [PHASE_W-1:0] RD_SCL_LO  = 3'd3;
   localparam logic [PHASE_W-1:0] RD_ACK_DRV = 3'd4;
   localparam logic [PHASE_W-1:0] RD_ACK_HI  = 3'd5;
   localparam logic [PHASE_W-1:0] RD_LAST    = 3'd6;

   op_type               cmd_ff, cmd_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [COUNT_W-1:0]   bits_ff, bits_in;
   logic [BYTE_W-1:0]    shift_ff, shift_in;
   logic [UNIT_W-1:0]    pre_ff, pre_in;
   logic [DELAY_W-1:0]   units_ff, units_in;
   logic                 ack_ff, ack_in;
   logic [BYTE_W-1:0]    rx_ff, rx_in;
   logic                 ackp_ff, ackp_in;
   logic                 done;
   logic                 seg;
   logic [UNIT_W-1:0]    unit_eff;
   logic [UNIT_W:0]      pre_sum;
   logic [DELAY_W-1:0]   units_dec;

   always_comb begin
      cmd_in    = cmd_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      phase_in  = phase_ff;
      bits_in   = bits_ff;
      shift_in  = shift_ff;
      pre_in    = pre_ff;
      units_in  = units_ff;
      ack_in    = ack_ff;
      rx_in     = rx_ff;
      ackp_in   = ackp_ff;
      done      = 1'b0;
      seg       = 1'b0;
      unit_eff  = (unit_ticks == '0) ? {{(UNIT_W-1){1'b0}}, 1'b1} : unit_ticks;
      pre_sum   = {1'b0, pre_ff} + {{UNIT_W{1'b0}}, 1'b1};
      units_dec = (units_ff != '0) ? units_ff - 3'd1 : units_ff;

      if (cmd_ff == OP_NONE) begin
         if (item.operation >= OP_START && item.operation <= OP_READ) begin
            cmd_in   = op_type'(item.operation);
            phase_in = '0;
            bits_in  = '0;
            shift_in = (item.operation == OP_WRITE) ? item.write_byte : '0;
            ackp_in  = item.ack_to_send;
            pre_in   = '0;
            seg      = 1'b1;
         end
      end else if (pre_sum >= {1'b0, unit_eff}) begin
         pre_in   = '0;
         units_in = units_dec;
         if (units_dec == '0) begin
            seg = 1'b1;
            // advance to the next segment
            unique case (cmd_ff)
               OP_START: begin
                  phase_in = phase_ff + 3'd1;
                  if (phase_ff == START_LAST) seg = 1'b0;
               end
               OP_STOP: begin
                  phase_in = phase_ff + 3'd1;
                  if (phase_ff == STOP_LAST) seg = 1'b0;
               end
               OP_WRITE: begin
                  if (phase_ff == WR_SCL_LO) begin
                     shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
                     bits_in  = bits_ff + 4'd1;
                     phase_in = (bits_in < BITS_PER_BYTE) ? WR_DATA : WR_REL;
                  end else begin
                     phase_in = phase_ff + 3'd1;
                     if (phase_ff == WR_LAST) seg = 1'b0;
                  end
               end
               default: begin
                  if (phase_ff == RD_SCL_LO) begin
                     bits_in  = bits_ff + 4'd1;
                     phase_in = (bits_in < BITS_PER_BYTE) ? RD_SCL_HI : RD_ACK_DRV;
                  end else begin
                     phase_in = phase_ff + 3'd1;
                     if (phase_ff == RD_LAST) begin
                        seg   = 1'b0;
                        rx_in = shift_ff;
                     end
                  end
               end
            endcase
            if (!seg) begin
               cmd_in   = OP_NONE;
               phase_in = '0;
               bits_in  = '0;
               done     = 1'b1;
            end
         end
      end else begin
         pre_in = pre_sum[UNIT_W-1:0];
      end

      // perform the action of the new segment and load its delay
      if (seg) begin
         unique case (cmd_in)
            OP_START: begin
               units_in = UNITS_SETUP;
               unique case (phase_in)
                  3'd0:    scl_in = 1'b1;
                  3'd1:    sda_in = 1'b1;
                  3'd2:    sda_in = 1'b0;
                  default: scl_in = 1'b0;
               endcase
            end
            OP_STOP: begin
               units_in = UNITS_SETUP;
               unique case (phase_in)
                  3'd0:    sda_in = 1'b0;
                  3'd1:    scl_in = 1'b1;
                  default: sda_in = 1'b1;
               endcase
            end
            OP_WRITE: begin
               unique case (phase_in)
                  WR_DATA: begin
                     sda_in = shift_in[BYTE_W-1]; units_in = UNITS_SETUP;
                  end
                  WR_SCL_HI:  begin scl_in = 1'b1; units_in = UNITS_HIGH;  end
                  WR_SCL_LO:  begin scl_in = 1'b0; units_in = UNITS_HOLD;  end
                  WR_REL:     begin sda_in = 1'b1; units_in = UNITS_SETUP; end
                  WR_ACK_HI:  begin scl_in = 1'b1; units_in = UNITS_SETUP; end
                  WR_ACK_SMP: begin
                     ack_in = ~item.sda_in; units_in = UNITS_HOLD;
                  end
                  default:    begin scl_in = 1'b0; units_in = UNITS_HIGH;  end
               endcase
            end
            default: begin
               unique case (phase_in)
                  RD_REL:    begin sda_in = 1'b1; units_in = UNITS_SETUP; end
                  RD_SCL_HI: begin scl_in = 1'b1; units_in = UNITS_SETUP; end
                  RD_SMP: begin
                     shift_in = {shift_in[BYTE_W-2:0], item.sda_in};
                     units_in = UNITS_HOLD;
                  end
                  RD_SCL_LO:  begin scl_in = 1'b0; units_in = UNITS_HIGH; end
                  RD_ACK_DRV: begin sda_in = ~ackp_in; units_in = UNITS_SETUP; end
                  RD_ACK_HI:  begin scl_in = 1'b1; units_in = UNITS_HIGH; end
                  default:    begin scl_in = 1'b0; units_in = UNITS_HIGH; end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= OP_NONE;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         phase_ff <= '0;
         bits_ff  <= '0;
         shift_ff <= '0;
         pre_ff   <= '0;
         units_ff <= '0;
         ack_ff   <= 1'b0;
         rx_ff    <= '0;
         ackp_ff  <= 1'b0;
      end else if (step) begin
         cmd_ff   <= cmd_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         pre_ff   <= pre_in;
         units_ff <= units_in;
         ack_ff   <= ack_in;
         rx_ff    <= rx_in;
         ackp_ff  <= ackp_in;
      end
   end

   always_comb begin
      result.scl_out      = scl_in;
      result.sda_out      = sda_in;
      result.busy_res     = (cmd_in != OP_NONE);
      result.done_res     = done;
      result.read_byte    = rx_in;
      result.ack_received = ack_in;
   end

endmodule

// ===== design/i2c_master_bit_sequencer.sv =====
`timescale 1ns / 1ps

// I2C master pin sequencer at the byte-command level.
// Each req beat is one tick of the bus timer. It carries a command (start,
// stop, write byte, read byte), taken only while no command is in progress,
// plus the sampled SDA level. Every req beat yields exactly one rsp beat with
// the open-drain SCL/SDA levels to drive (1 released, 0 pulled low), busy,
// a one-beat done pulse, the last read byte and the last write's ACK.
// Timing is counted in units of csr_wdata ticks (0 acts as 1); a start takes
// 12 units, a stop 9, a write 93 and a read 96.
// Throughput: one beat per cycle while the receiver does not stall. A req
// beat passes the input register, then the result register, before its rsp
// beat is presented; the sequencer step itself is single-pass logic between them.
// Reset (synchronous, active high) releases both lines, goes idle, clears
// read byte and ACK flag and sets the unit length to one tick.
// When the receiver stalls, hold the result register and the input register;
// req_tready drops only once both are full, and no tick is lost or repeated.
// Write csr only while idle.
module i2c_master_bit_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [2:0] operation, [10:3] write_byte, [11] ack_to_send, [12] sda_in
   input  logic [i2cms_pkg::DATA_W-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_byte,
   // [12] ack_received
   output logic [i2cms_pkg::DATA_W-1:0]  rsp_tdata,
   input  logic                          csr_we,
   input  logic [i2cms_pkg::UNIT_W-1:0]  csr_wdata
);
   import i2cms_pkg::*;

   logic                in_vld_ff, in_vld_in;
   req_item_type        in_item_ff;
   logic                rsp_vld_ff, rsp_vld_in;
   rsp_item_type        rsp_item_ff;
   rsp_item_type        seq_res;
   logic [UNIT_W-1:0]   unit_ff;
   logic                step;

   // Advance the sequencer when a tick is held and the result slot frees up
   assign step       = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || step;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tready) in_vld_in = req_tvalid;
      rsp_vld_in = rsp_vld_ff;
      if (step) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         unit_ff    <= {{(UNIT_W-1){1'b0}}, 1'b1};
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we) unit_ff <= csr_wdata;
      end
   end

   // Payload registers: input loads on accept, result loads on step, hold otherwise
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.operation   <= req_tdata[2:0];
         in_item_ff.write_byte  <= req_tdata[10:3];
         in_item_ff.ack_to_send <= req_tdata[11];
         in_item_ff.sda_in      <= req_tdata[12];
      end
      if (step) rsp_item_ff <= seq_res;
   end

   i2cms_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .unit_ticks (unit_ff),
      .result     (seq_res)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_item_ff.ack_received, rsp_item_ff.read_byte,
                        rsp_item_ff.done_res, rsp_item_ff.busy_res,
                        rsp_item_ff.sda_out, rsp_item_ff.scl_out};

   // A finishing beat never reports busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[2])
      else $error("done reported together with busy");

   // An empty result slot always lets a new tick in
   assert property (@(posedge clock) disable iff (reset)
      !rsp_vld_ff |-> req_tready)
      else $error("req stalled with result slot empty");

   // Nothing is presented right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid && !in_vld_ff)
      else $error("pipeline not cleared by reset");

   // A stalled result beat holds while the sequencer waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !step)
      else $error("sequencer advanced under a stalled result");

endmodule
